@@ rtl/core/kvt_pkg.sv @@
// Shared types and constants for the key/value table unit.
package kvt_pkg;

   localparam int OP_WIDTH     = 2;
   localparam int KEY_WIDTH    = 64;
   localparam int VALUE_WIDTH  = 64;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SET = 2'd0,
      OP_GET = 2'd1,
      OP_DEL = 2'd2
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FETCH,
      S_COMMIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic fetch;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic                match;
      logic                scan_done;
   } dp_stat_type;

endpackage

@@ rtl/core/kvt_req_if.sv @@
// Request channel: valid/ready handshake with operation, key and value.
interface kvt_req_if;
   import kvt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    operation;
   logic [KEY_WIDTH-1:0]   key;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output operation, output key, output value, input ready);
   modport sink (input valid, input operation, input key, input value, output ready);
endinterface

@@ rtl/core/kvt_rsp_if.sv @@
// Response channel: valid/ready handshake with found, value, status and count.
interface kvt_rsp_if;
   import kvt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [VALUE_WIDTH-1:0]  value_out;
   logic [STATUS_WIDTH-1:0] status;
   logic [COUNT_WIDTH-1:0]  entry_count;

   modport source (output valid, output found, output value_out, output status,
                   output entry_count, input ready);
   modport sink (input valid, input found, input value_out, input status,
                 input entry_count, output ready);
endinterface

@@ rtl/core/kvt_ctrl.sv @@
// Controller state machine sequencing scan, fetch, commit and response.
module kvt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  kvt_pkg::dp_stat_type stat,
   output kvt_pkg::dp_cmd_type  cmd
);
   import kvt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      op_known;

   assign op_known = (stat.op == OP_SET) || (stat.op == OP_GET) || (stat.op == OP_DEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!op_known) begin
               state_in = S_COMMIT;
            end else if (stat.match) begin
               state_in = (stat.op == OP_SET) ? S_COMMIT : S_FETCH;
            end else if (stat.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_FETCH: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule

@@ rtl/core/kvt_dpath.sv @@
// Datapath: key and value memories, scan pointer, entry count and response registers.
module kvt_dpath #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 64,
   parameter int VALUE_BITS  = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  kvt_pkg::dp_cmd_type                cmd,
   output kvt_pkg::dp_stat_type               stat,
   input  logic [kvt_pkg::OP_WIDTH-1:0]       req_operation,
   input  logic [kvt_pkg::KEY_WIDTH-1:0]      req_key,
   input  logic [kvt_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                               rsp_found,
   output logic [kvt_pkg::VALUE_WIDTH-1:0]    rsp_value_out,
   output logic [kvt_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic [kvt_pkg::COUNT_WIDTH-1:0]    rsp_entry_count
);
   import kvt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [KEY_BITS-1:0]   key_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

   logic [OP_WIDTH-1:0]    op_ff;
   logic [KEY_BITS-1:0]    key_ff;
   logic [VALUE_BITS-1:0]  val_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [CW-1:0]          ptr_ff;
   logic [AW-1:0]          idx_ff;
   logic [AW-1:0]          hit_ff;
   logic                   rd_vld_ff;
   logic                   rd_vld_in;
   logic                   found_ff;
   logic [KEY_BITS-1:0]    rd_key_ff;
   logic [VALUE_BITS-1:0]  rd_val_ff;
   logic                   rsp_found_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_in;
   status_type             rsp_status_ff;
   status_type             rsp_status_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;

   logic                  more;
   logic                  match;
   logic [CW-1:0]         last_cnt;
   logic [AW-1:0]         fetch_addr;
   logic [AW-1:0]         rd_addr;
   logic                  key_we;
   logic                  val_we;
   logic [AW-1:0]         wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;

   assign more       = ptr_ff < count_ff;
   assign match      = cmd.scan && rd_vld_ff && (rd_key_ff == key_ff);
   assign rd_vld_in  = cmd.scan && more;
   assign last_cnt   = count_ff - CW'(1);
   assign fetch_addr = (op_ff == OP_GET) ? hit_ff : last_cnt[AW-1:0];
   assign rd_addr    = cmd.fetch ? fetch_addr : ptr_ff[AW-1:0];

   assign stat.op        = op_ff;
   assign stat.match     = match;
   assign stat.scan_done = !rd_vld_ff && !more;

   always_comb begin
      key_we        = 1'b0;
      val_we        = 1'b0;
      wr_addr       = hit_ff;
      wr_key        = rd_key_ff;
      wr_val        = val_ff;
      count_in      = count_ff;
      rsp_value_in  = '0;
      rsp_status_in = ST_DONE;
      case (op_ff)
         OP_SET: begin
            if (found_ff) begin
               val_we = 1'b1;
            end else if (count_ff < CW'(TABLE_DEPTH)) begin
               key_we   = 1'b1;
               val_we   = 1'b1;
               wr_addr  = count_ff[AW-1:0];
               wr_key   = key_ff;
               count_in = count_ff + CW'(1);
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_GET: begin
            if (found_ff) begin
               rsp_value_in = VALUE_WIDTH'(rd_val_ff);
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         OP_DEL: begin
            if (found_ff) begin
               key_we   = 1'b1;
               val_we   = 1'b1;
               wr_val   = rd_val_ff;
               count_in = last_cnt;
            end else begin
               rsp_status_in = ST_ABSENT;
            end
         end
         default: begin
            rsp_status_in = ST_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ptr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
         if (cmd.load) begin
            ptr_ff   <= '0;
            found_ff <= 1'b0;
         end else begin
            if (rd_vld_in) begin
               ptr_ff <= ptr_ff + CW'(1);
            end
            if (match) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_operation;
         key_ff <= req_key[KEY_BITS-1:0];
         val_ff <= req_value[VALUE_BITS-1:0];
      end
      if (rd_vld_in) begin
         idx_ff <= ptr_ff[AW-1:0];
      end
      if (match) begin
         hit_ff <= idx_ff;
      end
      if (cmd.commit) begin
         rsp_found_ff  <= found_ff;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= COUNT_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
      if (cmd.commit && key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (cmd.commit && val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
endmodule

@@ rtl/core/key_value_table_set_get_delete_unit.sv @@
// Key/value table unit: set, get and delete over a linearly searched table.
//
// The table holds up to TABLE_DEPTH key/value pairs in two single-port-write
// memories with registered reads. One request is handled at a time. The key
// memory is scanned one entry per cycle through its read port. A request that
// finds no match scans all valid entries before its response. A hit at entry h
// ends the scan early. A set that hits then commits directly. A get or delete
// that hits first passes through a fetch state, which reads the value or the
// last entry. The unit is ready again in the cycle after the response is taken.
// The request channel is ready only when the unit is idle, and the response is
// held until taken. Delete moves the last entry into the freed slot, so entry
// order is not preserved. Keys and values keep only their low KEY_BITS and
// VALUE_BITS bits. No clearing pass is needed after reset. Operation code 3
// changes nothing and answers done with the count.
module key_value_table_set_get_delete_unit #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 64,
   parameter int VALUE_BITS  = 64
) (
   input logic             clock,
   input logic             reset,
   kvt_req_if.sink         req_chan,
   kvt_rsp_if.source       rsp_chan
);
   import kvt_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;
   logic        rsp_valid;

   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   kvt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_chan.operation),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .rsp_found       (rsp_chan.found),
      .rsp_value_out   (rsp_chan.value_out),
      .rsp_status      (rsp_chan.status),
      .rsp_entry_count (rsp_chan.entry_count)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
endmodule

@@ rtl/core/kvt_checker.sv @@
// Port-level assertions for the key/value table unit and their bind.
module kvt_checker #(
   parameter int TABLE_DEPTH = 128
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [kvt_pkg::VALUE_WIDTH-1:0]    rsp_value_out,
   input logic [kvt_pkg::STATUS_WIDTH-1:0]   rsp_status,
   input logic [kvt_pkg::COUNT_WIDTH-1:0]    rsp_entry_count
);
   import kvt_pkg::*;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response raised in the cycle after a request");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((TABLE_DEPTH > 255) ||
                     (32'(rsp_entry_count) <= 32'(TABLE_DEPTH))))
      else $error("entry count above table depth");

   a_status_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ST_DONE) ||
                     ((rsp_status == ST_FULL || rsp_status == ST_ABSENT) && !rsp_found)) &&
                    ((rsp_value_out == '0) || rsp_found))
      else $error("inconsistent status, found and value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) &&
         $stable(rsp_value_out) && $stable(rsp_status) && $stable(rsp_entry_count)))
      else $error("stalled response changed");
endmodule

bind key_value_table_set_get_delete_unit kvt_checker #(
   .TABLE_DEPTH (TABLE_DEPTH)
) u_kvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_found       (rsp_chan.found),
   .rsp_value_out   (rsp_chan.value_out),
   .rsp_status      (rsp_chan.status),
   .rsp_entry_count (rsp_chan.entry_count)
);

@@ sim/kvt_table_checker.sv @@
// Checker for the key/value table unit: mirrors the table and compares every response.
module kvt_table_checker #(
   parameter int TABLE_DEPTH = 128,
   parameter int KEY_BITS    = 64,
   parameter int VALUE_BITS  = 64
) (
   input  logic clock,
   input  logic reset,
   kvt_req_if   req_mon,
   kvt_rsp_if   rsp_mon,
   output int   mismatch_total,
   output int   results_awaited
);
   import kvt_pkg::*;

   localparam logic [KEY_WIDTH-1:0] KEY_MASK =
      (KEY_BITS >= KEY_WIDTH) ? '1 : ((KEY_WIDTH'(1) << KEY_BITS) - KEY_WIDTH'(1));
   localparam logic [VALUE_WIDTH-1:0] VALUE_MASK =
      (VALUE_BITS >= VALUE_WIDTH) ? '1 : ((VALUE_WIDTH'(1) << VALUE_BITS) - VALUE_WIDTH'(1));

   typedef struct packed {
      logic                   found;
      logic [VALUE_WIDTH-1:0] value_out;
      status_type             status;
      logic [COUNT_WIDTH-1:0] entry_count;
   } lookup_result_type;

   logic [KEY_WIDTH-1:0]   mirror_keys   [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] mirror_values [TABLE_DEPTH];
   int                     mirror_count = 0;
   lookup_result_type      pending_lookups [$];

   initial begin
      mismatch_total  = 0;
      results_awaited = 0;
   end

   function automatic lookup_result_type predict_lookup(input logic [OP_WIDTH-1:0] op,
                                                        input logic [KEY_WIDTH-1:0] key_in,
                                                        input logic [VALUE_WIDTH-1:0] value_in);
      lookup_result_type      res;
      logic [KEY_WIDTH-1:0]   k;
      logic [VALUE_WIDTH-1:0] v;
      int                     hit;
      k = key_in & KEY_MASK;
      v = value_in & VALUE_MASK;
      res = '0;
      res.status = ST_DONE;
      hit = -1;
      for (int i = 0; i < mirror_count; i++) begin
         if (hit < 0 && mirror_keys[i] == k) hit = i;
      end
      case (op)
         OP_SET: begin
            if (hit >= 0) begin
               res.found = 1'b1;
               mirror_values[hit] = v;
            end else if (mirror_count < TABLE_DEPTH) begin
               mirror_keys[mirror_count]   = k;
               mirror_values[mirror_count] = v;
               mirror_count++;
            end else begin
               res.status = ST_FULL;
            end
         end
         OP_GET: begin
            if (hit >= 0) begin
               res.found     = 1'b1;
               res.value_out = mirror_values[hit];
            end else begin
               res.status = ST_ABSENT;
            end
         end
         OP_DEL: begin
            if (hit >= 0) begin
               res.found = 1'b1;
               mirror_keys[hit]   = mirror_keys[mirror_count-1];
               mirror_values[hit] = mirror_values[mirror_count-1];
               mirror_count--;
            end else begin
               res.status = ST_ABSENT;
            end
         end
         default: ;
      endcase
      res.entry_count = COUNT_WIDTH'(mirror_count);
      return res;
   endfunction

   task automatic note_mismatch(input string what, input lookup_result_type exp,
                                input lookup_result_type act);
      if (mismatch_total < 10) begin
         $display("%s: expected found=%0d value=%h status=%0d count=%0d,",
                  what, exp.found, exp.value_out, exp.status, exp.entry_count);
         $display("   got found=%0d value=%h status=%0d count=%0d",
                  act.found, act.value_out, act.status, act.entry_count);
      end
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      lookup_result_type exp, act;
      if (reset) begin
         mirror_count = 0;
         pending_lookups.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            act.found       = rsp_mon.found;
            act.value_out   = rsp_mon.value_out;
            act.status      = status_type'(rsp_mon.status);
            act.entry_count = rsp_mon.entry_count;
            if (pending_lookups.size() == 0) begin
               note_mismatch("unexpected response", '0, act);
            end else begin
               exp = pending_lookups.pop_front();
               if (act !== exp) note_mismatch("response", exp, act);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            pending_lookups.push_back(predict_lookup(req_mon.operation, req_mon.key,
                                                     req_mon.value));
         end
      end
      results_awaited = pending_lookups.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the key/value table unit: drives requests, stalls responses, gives the verdict.
module tb_top;
   import kvt_pkg::*;

   localparam int TABLE_DEPTH  = 128;
   localparam int KEY_BITS     = 64;
   localparam int VALUE_BITS   = 64;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
   localparam int PHASE_ITEMS  = 650;
   localparam int POOL_SIZE    = 256;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALT_FIVE = 64'h5555_5555_5555_5555;
   localparam logic [63:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic rsp_take = 1'b0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   stall_cycles = 0;
   int   mismatch_total;
   int   results_awaited;
   logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];

   kvt_req_if req_chan ();
   kvt_rsp_if rsp_chan ();

   key_value_table_set_get_delete_unit #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   kvt_table_checker #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) table_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_total  (mismatch_total),
      .results_awaited (results_awaited)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   assign rsp_chan.ready = rsp_take;

   always @(negedge clock) begin
      rsp_take <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("key_value_table_set_get_delete_unit: mismatch");
         $finish;
      end
   end

   task automatic issue_request(input logic [OP_WIDTH-1:0] op, input logic [KEY_WIDTH-1:0] k,
                                input logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.key       <= k;
      req_chan.value     <= v;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_awaited != 0) @(negedge clock);
   endtask

   task automatic run_random_phase(input int item_total);
      int                     set_pct;
      int                     del_pct;
      int                     span;
      int                     roll;
      logic [OP_WIDTH-1:0]    op;
      logic [KEY_WIDTH-1:0]   k;
      logic [VALUE_WIDTH-1:0] v;
      set_pct = 40;
      del_pct = 30;
      span = POOL_SIZE;
      for (int n = 0; n < item_total; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: begin set_pct = 70; del_pct = 10; end
               1: begin set_pct = 40; del_pct = 30; end
               default: begin set_pct = 5; del_pct = 85; end
            endcase
            span = ($urandom_range(0, 3) == 0) ? 16 : POOL_SIZE;
         end
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3) op = OP_UNUSED;
         else if (roll < set_pct) op = OP_SET;
         else if (roll < set_pct + del_pct) op = OP_DEL;
         else op = OP_GET;
         if ($urandom_range(0, 19) == 0) k = {$urandom, $urandom};
         else k = key_pool[$urandom_range(0, span - 1)];
         case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
         endcase
         issue_request(op, k, v);
      end
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_SET;
      req_chan.key       = '0;
      req_chan.value     = '0;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 49;
      issue_request(OP_GET, '0, '0);
      issue_request(OP_DEL, '0, '0);
      issue_request(OP_UNUSED, ALT_A, ALT_FIVE);
      issue_request(OP_SET, '0, '0);
      issue_request(OP_SET, ALL_ONES, ALL_ONES);
      issue_request(OP_SET, ALT_FIVE, ALT_A);
      issue_request(OP_GET, '0, ALL_ONES);
      issue_request(OP_GET, ALL_ONES, '0);
      issue_request(OP_SET, '0, ALL_ONES);
      issue_request(OP_GET, '0, '0);
      issue_request(OP_DEL, '0, '0);
      issue_request(OP_GET, ALT_FIVE, '0);
      issue_request(OP_GET, '0, '0);
      issue_request(OP_DEL, ALL_ONES, '0);
      issue_request(OP_UNUSED, ALL_ONES, ALL_ONES);
      issue_request(OP_DEL, ALT_FIVE, '0);
      issue_request(OP_GET, ALT_FIVE, '0);
      issue_request(OP_SET, ALT_A, ALT_FIVE);
      issue_request(OP_DEL, ALT_A, '0);
      issue_request(OP_SET, '0, '0);
      wait_for_responses();

      run_random_phase(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 49;
      recv_idle_pct = 8;
      run_random_phase(PHASE_ITEMS);
      wait_for_responses();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);
      wait_for_responses();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_total == 0 && results_awaited == 0) begin
         $display("key_value_table_set_get_delete_unit: match");
      end else begin
         $display("key_value_table_set_get_delete_unit: mismatch");
      end
      $finish;
   end

endmodule
